@@ rtl/rlfe_pkg.sv @@
// ----------------------------------------------------------------------------
// rlfe_pkg
// Shared types and fixed widths for the linear RGB fade engine.
// ----------------------------------------------------------------------------
package rlfe_pkg;

    localparam int CHAN_W    = 8;
    localparam int STEP_W    = 6;
    localparam int DELAY_W   = 16;
    localparam int FADE_MS_W = 22;
    localparam int NUM_CHAN  = 3;

    localparam int RECIP_SHIFT = 28;

    typedef enum logic
    {
        MODE_SET  = 1'b0,
        MODE_TICK = 1'b1
    } mode_t;

    typedef logic [CHAN_W-1:0] chan_t;

endpackage

@@ rtl/rgb_linear_fade_engine.sv @@
// ----------------------------------------------------------------------------
// rgb_linear_fade_engine
// Scales the requested color by power and brightness, then fades linearly
// from the shown color to it in FADE_STEPS steps, or at once for a zero fade.
// ----------------------------------------------------------------------------
//  channel  signals                         payload
//  input    in_valid, in_stall (out)        set request or millisecond tick
//  output   out_valid, out_stall (in)       color, step_number, final_step
//
//  A request is taken every cycle unless in_stall is high.
//  Stage one registers the request with its scaled target and step delay,
//  stage two updates the fade state and loads the result register.
//  Reset clears all control state; brightness comes up at full scale.
//  A held result stalls the input only while stage one holds another request
//  that produces a result.
module rgb_linear_fade_engine
    import rlfe_pkg::*;
#(
    parameter int FADE_STEPS = 50
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  logic                 update_power,
    input  logic                 power_on,
    input  logic                 update_brightness,
    input  logic [CHAN_W-1:0]    brightness_in,
    input  logic                 update_color,
    input  logic [CHAN_W-1:0]    red_in,
    input  logic [CHAN_W-1:0]    green_in,
    input  logic [CHAN_W-1:0]    blue_in,
    input  logic [FADE_MS_W-1:0] fade_ms,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CHAN_W-1:0]    out_red,
    output logic [CHAN_W-1:0]    out_green,
    output logic [CHAN_W-1:0]    out_blue,
    output logic [STEP_W-1:0]    step_number,
    output logic                 final_step
);

    localparam int REM_W    = (FADE_STEPS > 2) ? $clog2(FADE_STEPS) : 1;
    localparam int RECIP_W  = RECIP_SHIFT;
    localparam int MSPROD_W = FADE_MS_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(FADE_STEPS) - 64'd1) / 64'(FADE_STEPS));
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(FADE_STEPS);
    localparam logic [REM_W:0]    STEPS_WIDE = (REM_W+1)'(FADE_STEPS);
    localparam int TAB_DEPTH = 1 << CHAN_W;

    // Quotient and remainder of every channel distance by the step count.
    chan_t            quo_tab [TAB_DEPTH];
    logic [REM_W-1:0] rem_tab [TAB_DEPTH];

    for (genvar g = 0; g < TAB_DEPTH; g++)
    begin : g_tab
        localparam int Q = g / FADE_STEPS;
        localparam int R = g % FADE_STEPS;
        assign quo_tab[g] = CHAN_W'(Q);
        assign rem_tab[g] = REM_W'(R);
    end

    // Stage one: stored settings, scaled target and step delay.
    logic        stored_power_reg;
    chan_t       stored_bright_reg;
    chan_t       stored_color_reg [NUM_CHAN];

    logic        s1_valid_reg;
    mode_t       s1_mode_reg;
    chan_t       s1_target_reg [NUM_CHAN];
    logic [DELAY_W-1:0] s1_delay_reg;
    logic        s1_zero_reg;

    logic        eff_power;
    chan_t       eff_bright;
    chan_t       eff_color [NUM_CHAN];
    chan_t       in_color  [NUM_CHAN];
    chan_t       scaled    [NUM_CHAN];
    logic [MSPROD_W-1:0]  ms_prod;
    logic [FADE_MS_W-1:0] ms_quo;
    logic [DELAY_W-1:0]   delay_sat;
    logic        in_take;
    logic        commit;

    assign in_color[0] = red_in;
    assign in_color[1] = green_in;
    assign in_color[2] = blue_in;

    assign in_take  = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !commit;

    assign eff_power  = update_power ? power_on : stored_power_reg;
    assign eff_bright = update_brightness ? brightness_in : stored_bright_reg;

    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_scale
        logic [2*CHAN_W-1:0] prod;
        logic [2*CHAN_W:0]   sum;

        assign eff_color[c] = update_color ? in_color[c] : stored_color_reg[c];
        assign prod = eff_power ? (eff_bright * eff_color[c]) : '0;
        assign sum  = (2*CHAN_W+1)'(prod) + (2*CHAN_W+1)'(prod >> CHAN_W)
                    + (2*CHAN_W+1)'(1);
        assign scaled[c] = sum[2*CHAN_W-1:CHAN_W];
    end

    assign ms_prod   = MSPROD_W'(fade_ms) * MSPROD_W'(RECIP);
    assign ms_quo    = ms_prod[MSPROD_W-1:RECIP_SHIFT];
    assign delay_sat = (|ms_quo[FADE_MS_W-1:DELAY_W]) ? '1 : ms_quo[DELAY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_power_reg  <= 1'b0;
            stored_bright_reg <= '1;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                stored_color_reg[c] <= '0;
            end
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
                if (mode_t'(mode) == MODE_SET)
                begin
                    stored_power_reg  <= eff_power;
                    stored_bright_reg <= eff_bright;
                    for (int c = 0; c < NUM_CHAN; c++)
                    begin
                        stored_color_reg[c] <= eff_color[c];
                    end
                end
            end
            else if (commit)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg  <= mode_t'(mode);
            s1_delay_reg <= delay_sat;
            s1_zero_reg  <= (ms_quo == '0);
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                s1_target_reg[c] <= scaled[c];
            end
        end
    end

    // Stage two: fade state and result register.
    chan_t              shown_reg  [NUM_CHAN];
    chan_t              start_reg  [NUM_CHAN];
    chan_t              target_reg [NUM_CHAN];
    chan_t              qinc_reg   [NUM_CHAN];
    logic [REM_W-1:0]   rinc_reg   [NUM_CHAN];
    chan_t              qacc_reg   [NUM_CHAN];
    logic [REM_W-1:0]   racc_reg   [NUM_CHAN];
    logic               neg_reg    [NUM_CHAN];
    logic [STEP_W-1:0]  step_count_reg;
    logic [DELAY_W-1:0] tick_count_reg;
    logic [DELAY_W-1:0] step_delay_reg;
    logic               fading_reg;

    chan_t              shown_next  [NUM_CHAN];
    chan_t              start_next  [NUM_CHAN];
    chan_t              target_next [NUM_CHAN];
    chan_t              qinc_next   [NUM_CHAN];
    logic [REM_W-1:0]   rinc_next   [NUM_CHAN];
    chan_t              qacc_next   [NUM_CHAN];
    logic [REM_W-1:0]   racc_next   [NUM_CHAN];
    logic               neg_next    [NUM_CHAN];
    logic [STEP_W-1:0]  step_count_next;
    logic [DELAY_W-1:0] tick_count_next;
    logic [DELAY_W-1:0] step_delay_next;
    logic               fading_next;

    logic               out_valid_reg;
    chan_t              out_color_reg [NUM_CHAN];
    logic [STEP_W-1:0]  out_step_reg;
    logic               out_final_reg;
    chan_t              res_color [NUM_CHAN];
    logic [STEP_W-1:0]  res_step;
    logic               res_final;

    chan_t              cmd_val   [NUM_CHAN];
    chan_t              cmd_qinc  [NUM_CHAN];
    logic [REM_W-1:0]   cmd_rinc  [NUM_CHAN];
    logic               cmd_neg   [NUM_CHAN];
    chan_t              tick_val  [NUM_CHAN];
    chan_t              tick_qacc [NUM_CHAN];
    logic [REM_W-1:0]   tick_racc [NUM_CHAN];

    logic               is_cmd;
    logic [DELAY_W-1:0] tick_inc;
    logic               tick_hit;
    logic [STEP_W-1:0]  step_adv;
    logic               emit;

    assign is_cmd   = (s1_mode_reg == MODE_SET);
    assign tick_inc = tick_count_reg + DELAY_W'(1);
    assign tick_hit = fading_reg && (tick_inc >= step_delay_reg);
    assign step_adv = step_count_reg + STEP_W'(1);
    assign emit     = s1_valid_reg && (is_cmd || tick_hit);
    assign commit   = s1_valid_reg && (!emit || !out_valid_reg || !out_stall);

    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_chan
        logic [CHAN_W:0]  diff;
        chan_t            mag;
        logic [CHAN_W:0]  cmd_sum;
        logic [REM_W:0]   rsum;
        logic             wrap;
        logic [CHAN_W:0]  tick_sum;

        assign diff        = {1'b0, s1_target_reg[c]} - {1'b0, shown_reg[c]};
        assign cmd_neg[c]  = diff[CHAN_W];
        assign mag         = cmd_neg[c] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
        assign cmd_qinc[c] = quo_tab[mag];
        assign cmd_rinc[c] = rem_tab[mag];
        assign cmd_sum     = cmd_neg[c]
                           ? ({1'b0, shown_reg[c]} - {1'b0, cmd_qinc[c]})
                           : ({1'b0, shown_reg[c]} + {1'b0, cmd_qinc[c]});
        assign cmd_val[c]  = s1_zero_reg ? s1_target_reg[c] : cmd_sum[CHAN_W-1:0];

        assign rsum         = {1'b0, racc_reg[c]} + {1'b0, rinc_reg[c]};
        assign wrap         = (rsum >= STEPS_WIDE);
        assign tick_racc[c] = wrap ? REM_W'(rsum - STEPS_WIDE) : rsum[REM_W-1:0];
        assign tick_qacc[c] = qacc_reg[c] + qinc_reg[c] + CHAN_W'(wrap);
        assign tick_sum     = neg_reg[c]
                            ? ({1'b0, start_reg[c]} - {1'b0, tick_qacc[c]})
                            : ({1'b0, start_reg[c]} + {1'b0, tick_qacc[c]});
        assign tick_val[c]  = tick_sum[CHAN_W-1:0];
    end

    always_comb
    begin
        step_count_next = step_count_reg;
        tick_count_next = tick_count_reg;
        step_delay_next = step_delay_reg;
        fading_next     = fading_reg;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            shown_next[c]  = shown_reg[c];
            start_next[c]  = start_reg[c];
            target_next[c] = target_reg[c];
            qinc_next[c]   = qinc_reg[c];
            rinc_next[c]   = rinc_reg[c];
            qacc_next[c]   = qacc_reg[c];
            racc_next[c]   = racc_reg[c];
            neg_next[c]    = neg_reg[c];
        end
        if (commit)
        begin
            if (is_cmd)
            begin
                step_delay_next = s1_delay_reg;
                tick_count_next = '0;
                step_count_next = s1_zero_reg ? LAST_STEP : STEP_W'(1);
                fading_next     = !s1_zero_reg;
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    start_next[c]  = shown_reg[c];
                    target_next[c] = s1_target_reg[c];
                    qinc_next[c]   = cmd_qinc[c];
                    rinc_next[c]   = cmd_rinc[c];
                    qacc_next[c]   = cmd_qinc[c];
                    racc_next[c]   = cmd_rinc[c];
                    neg_next[c]    = cmd_neg[c];
                    shown_next[c]  = cmd_val[c];
                end
            end
            else if (fading_reg)
            begin
                if (!tick_hit)
                begin
                    tick_count_next = tick_inc;
                end
                else
                begin
                    tick_count_next = '0;
                    step_count_next = step_adv;
                    fading_next     = (step_adv != LAST_STEP);
                    for (int c = 0; c < NUM_CHAN; c++)
                    begin
                        qacc_next[c]  = tick_qacc[c];
                        racc_next[c]  = tick_racc[c];
                        shown_next[c] = tick_val[c];
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (is_cmd)
        begin
            res_step  = s1_zero_reg ? LAST_STEP : STEP_W'(1);
            res_final = s1_zero_reg;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                res_color[c] = cmd_val[c];
            end
        end
        else
        begin
            res_step  = step_adv;
            res_final = (step_adv == LAST_STEP);
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                res_color[c] = tick_val[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= '0;
            tick_count_reg <= '0;
            step_delay_reg <= '0;
            fading_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                shown_reg[c]  <= '0;
                start_reg[c]  <= '0;
                target_reg[c] <= '0;
                qinc_reg[c]   <= '0;
                rinc_reg[c]   <= '0;
                qacc_reg[c]   <= '0;
                racc_reg[c]   <= '0;
                neg_reg[c]    <= 1'b0;
            end
        end
        else
        begin
            step_count_reg <= step_count_next;
            tick_count_reg <= tick_count_next;
            step_delay_reg <= step_delay_next;
            fading_reg     <= fading_next;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                shown_reg[c]  <= shown_next[c];
                start_reg[c]  <= start_next[c];
                target_reg[c] <= target_next[c];
                qinc_reg[c]   <= qinc_next[c];
                rinc_reg[c]   <= rinc_next[c];
                qacc_reg[c]   <= qacc_next[c];
                racc_reg[c]   <= racc_next[c];
                neg_reg[c]    <= neg_next[c];
            end
            if (commit && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && emit)
        begin
            out_step_reg  <= res_step;
            out_final_reg <= res_final;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                out_color_reg[c] <= res_color[c];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_red     = out_color_reg[0];
    assign out_green   = out_color_reg[1];
    assign out_blue    = out_color_reg[2];
    assign step_number = out_step_reg;
    assign final_step  = out_final_reg;

endmodule
